// File: rtl/cross_neighbor_peak_clip_core_defines.svh
// Assertion macros shared by the peak clip RTL.
// Depends on clk_i and rst_ni being visible in the module that expands them.
`ifndef CROSS_NEIGHBOR_PEAK_CLIP_CORE_DEFINES_SVH
`define CROSS_NEIGHBOR_PEAK_CLIP_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define CNPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define CNPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CNPC_ASSERT(lbl, prop, msg)
`define CNPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/cnpc_pkg.sv
// Shared types and constants of the four-neighbor peak clip core.
// No dependencies; used by cnpc_linebuf and cross_neighbor_peak_clip_core.
package cnpc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int PIXEL_BITS = 16;

  localparam int AW       = $clog2(MAX_WIDTH);
  localparam int CFG_BITS = 11;
  localparam int ROW_BITS = 11;
  localparam int LW       = (CFG_BITS > AW + 1) ? CFG_BITS : AW + 1;
  localparam int TDATA_W  = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int IDX_BITS = 2;

  localparam logic [CFG_BITS-1:0] CFG_DIM_RESET = CFG_BITS'(1024);

  localparam logic [IDX_BITS-1:0] CFG_FRAME_WIDTH  = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] CFG_FRAME_HEIGHT = IDX_BITS'(1);

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [AW-1:0]         addr_t;

  // Line store access from the pixel datapath.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    pix_t  wcenter;
    pix_t  wabove;
    addr_t raddr;
  } lb_req_t;

  // Line store read data, already zeroed for entries never written.
  typedef struct packed {
    pix_t center;
    pix_t right;
    pix_t above;
  } lb_rd_t;

endpackage

// File: rtl/cnpc_linebuf.sv
// Two line stores (center row, row above) with registered reads and write bypass.
// Depends on cnpc_pkg. A fill count marks the written prefix; other entries read as zero.
module cnpc_linebuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cnpc_pkg::lb_req_t req_i,
  output cnpc_pkg::lb_rd_t  rd_o
);

  cnpc_pkg::pix_t line_center [cnpc_pkg::MAX_WIDTH];
  cnpc_pkg::pix_t line_above  [cnpc_pkg::MAX_WIDTH];

  cnpc_pkg::pix_t  center_rd_q, right_rd_q, above_rd_q;
  cnpc_pkg::addr_t raddr_q;
  logic [cnpc_pkg::AW:0] fill_q, fill_d;
  logic [cnpc_pkg::AW:0] raddr_p1, waddr_p1, raddr_q_p1;
  cnpc_pkg::addr_t right_addr;

  assign raddr_p1   = {1'b0, req_i.raddr} + 1'b1;
  assign right_addr = raddr_p1[cnpc_pkg::AW-1:0];
  assign waddr_p1   = {1'b0, req_i.waddr} + 1'b1;
  assign raddr_q_p1 = {1'b0, raddr_q} + 1'b1;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      line_center[req_i.waddr] <= req_i.wcenter;
      line_above[req_i.waddr]  <= req_i.wabove;
    end
  end

  // Forward a same-edge write into the read registers.
  always_ff @(posedge clk_i) begin
    center_rd_q <= (req_i.we && req_i.waddr == req_i.raddr) ? req_i.wcenter
                                                            : line_center[req_i.raddr];
    right_rd_q  <= (req_i.we && req_i.waddr == right_addr) ? req_i.wcenter
                                                           : line_center[right_addr];
    above_rd_q  <= (req_i.we && req_i.waddr == req_i.raddr) ? req_i.wabove
                                                            : line_above[req_i.raddr];
  end

  always_comb begin
    fill_d = fill_q;
    if (req_i.we && waddr_p1 > fill_q) fill_d = waddr_p1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      raddr_q <= '0;
    end else begin
      fill_q  <= fill_d;
      raddr_q <= req_i.raddr;
    end
  end

  assign rd_o.center = ({1'b0, raddr_q} < fill_q) ? center_rd_q : '0;
  assign rd_o.above  = ({1'b0, raddr_q} < fill_q) ? above_rd_q  : '0;
  assign rd_o.right  = (raddr_q_p1 < fill_q)      ? right_rd_q  : '0;

endmodule

// File: rtl/cross_neighbor_peak_clip_core.sv
// Top level of the four-neighbor peak clip filter over a raster pixel stream.
// Depends on cnpc_pkg, cnpc_linebuf and cross_neighbor_peak_clip_core_defines.svh.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tdata: pixel_in; tuser: action
//  m_axis   | out | m_axis_tvalid/tready   | tdata: pixel_out; tlast: row_last;
//           |     |                        | tuser: frame_last
//  cfg      | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i (always ready)
//
// One pixel per clock sustained while the output is not stalled: accept into an input
// register, process it against the line store read data and load the result register.
// The line store read port is addressed with the next column so the data for each
// transaction is ready in time.
// The result register stalls only the item that must emit; reset clears counters,
// configuration (1024 x 1024) and the line store fill count, with no clearing pass.
`include "cross_neighbor_peak_clip_core_defines.svh"

module cross_neighbor_peak_clip_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cnpc_pkg::TDATA_W-1:0]    s_axis_tdata,   // [15:0] pixel_in
  input  logic                            s_axis_tuser,   // [0] action
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cnpc_pkg::TDATA_W-1:0]    m_axis_tdata,   // [15:0] pixel_out
  output logic                            m_axis_tlast,   // row_last
  output logic                            m_axis_tuser,   // [0] frame_last
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cnpc_pkg::IDX_BITS-1:0]   cfg_index_i,
  input  logic [cnpc_pkg::CFG_BITS-1:0]   cfg_data_i
);

  localparam int AW = cnpc_pkg::AW;
  localparam int LW = cnpc_pkg::LW;
  localparam int RB = cnpc_pkg::ROW_BITS;

  // Configuration registers.
  logic [cnpc_pkg::CFG_BITS-1:0] width_q, width_d, height_q, height_d;

  // Input register.
  logic           s0_valid_q, s0_valid_d;
  logic           s0_action_q;
  cnpc_pkg::pix_t s0_pix_q;

  // Frame position and left neighbor.
  cnpc_pkg::addr_t col_q, col_d;
  logic [RB-1:0]   row_q, row_d;
  cnpc_pkg::pix_t  left_q, left_d;

  // Result register.
  logic           out_valid_q, out_valid_d;
  cnpc_pkg::pix_t out_pix_q;
  logic           out_rlast_q, out_flast_q;

  // Datapath.
  logic [LW-1:0]   w_eff, w_m1, col_p1_ext;
  logic [AW:0]     col_p1;
  cnpc_pkg::addr_t col_eff, col_next;
  logic [RB-1:0]   h_eff, row_eff;
  logic [RB:0]     row_p1;
  logic            drain, ignore, emit, go, step, col_wrap;
  logic            row_last, frame_last;
  cnpc_pkg::pix_t  pix, up, left, right, center, hi_a, hi_b, hi, res;
  cnpc_pkg::lb_req_t lb_req;
  cnpc_pkg::lb_rd_t  lb_rd;

  cnpc_linebuf u_linebuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lb_req),
    .rd_o   (lb_rd)
  );

  // Clamp width to 1..MAX_WIDTH and height to at least one row.
  always_comb begin
    w_eff = LW'(width_q);
    if (width_q == '0) w_eff = LW'(1);
    if (w_eff > LW'(cnpc_pkg::MAX_WIDTH)) w_eff = LW'(cnpc_pkg::MAX_WIDTH);
    w_m1 = w_eff - LW'(1);
    h_eff = (height_q == '0) ? RB'(1) : RB'(height_q);
  end

  // Treat an out-of-range column as the last one and an overrun row as the drain row.
  always_comb begin
    col_eff    = (LW'(col_q) >= w_eff) ? w_m1[AW-1:0] : col_q;
    col_p1     = {1'b0, col_eff} + 1'b1;
    col_p1_ext = LW'(col_p1);
    col_wrap   = (col_p1_ext >= w_eff);
    col_next   = col_wrap ? '0 : col_p1[AW-1:0];
    row_eff    = (row_q > h_eff) ? h_eff : row_q;
    row_p1     = {1'b0, row_eff} + 1'b1;
    drain      = (row_eff == h_eff);
    row_last   = (LW'(col_eff) == w_m1);
    frame_last = row_last && drain;
  end

  // Drop drain ticks that come before the frame is complete.
  assign ignore = s0_action_q && !drain;
  assign emit   = !ignore && (row_eff != '0);
  assign go     = s0_valid_q && (!emit || !out_valid_q || m_axis_tready);
  assign step   = go && !ignore;

  // Clip the center pixel to the largest cross neighbor.
  always_comb begin
    pix    = drain ? '0 : s0_pix_q;
    center = lb_rd.center;
    up     = lb_rd.above;
    left   = (col_eff == '0) ? '0 : left_q;
    right  = col_wrap ? '0 : lb_rd.right;
    hi_a   = (left > up) ? left : up;
    hi_b   = (right > pix) ? right : pix;
    hi     = (hi_a > hi_b) ? hi_a : hi_b;
    res    = (center < hi) ? center : hi;
  end

  // Write the current column and read ahead at the column of the next transaction.
  always_comb begin
    lb_req.we      = step;
    lb_req.waddr   = col_eff;
    lb_req.wcenter = pix;
    lb_req.wabove  = (row_eff == '0) ? '0 : center;
    lb_req.raddr   = step ? col_next : col_eff;
  end

  // Advance column and row after each processed pixel.
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    left_d = left_q;
    if (step) begin
      left_d = center;
      col_d  = col_next;
      if (col_wrap) begin
        row_d = (row_p1 > {1'b0, h_eff}) ? '0 : row_p1[RB-1:0];
      end else begin
        row_d = row_eff;
      end
    end
  end

  assign s_axis_tready = !s0_valid_q || go;

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (go) s0_valid_d = 1'b0;
    if (s_axis_tvalid && s_axis_tready) s0_valid_d = 1'b1;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (go && emit) out_valid_d = 1'b1;
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cnpc_pkg::CFG_FRAME_WIDTH:  width_d  = cfg_data_i;
        cnpc_pkg::CFG_FRAME_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= cnpc_pkg::CFG_DIM_RESET;
      height_q    <= cnpc_pkg::CFG_DIM_RESET;
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      s0_valid_q  <= s0_valid_d;
      out_valid_q <= out_valid_d;
      col_q       <= col_d;
      row_q       <= row_d;
      left_q      <= left_d;
    end
  end

  // Payload registers: hold the input item and the result.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s0_action_q <= s_axis_tuser;
      s0_pix_q    <= s_axis_tdata[cnpc_pkg::PIXEL_BITS-1:0];
    end
    if (go && emit) begin
      out_pix_q   <= res;
      out_rlast_q <= row_last;
      out_flast_q <= frame_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = cnpc_pkg::TDATA_W'(out_pix_q);
  assign m_axis_tlast  = out_rlast_q;
  assign m_axis_tuser  = out_flast_q;

  `CNPC_ASSERT(a_frame_end_rewinds, (go && emit && frame_last) |=> (col_q == '0 && row_q == '0), "counters not cleared after frame end")
  `CNPC_ASSERT(a_result_has_source, $rose(out_valid_q) |-> $past(go && emit), "result appeared without a processed pixel")
  `CNPC_ASSERT(a_accept_fills_s0, (s_axis_tvalid && s_axis_tready) |=> s0_valid_q, "accepted transaction lost")
  `CNPC_ASSERT(a_no_overwrite, (go && emit) |-> (!out_valid_q || m_axis_tready), "result register overwritten while stalled")

endmodule
